// ===== rtl/core/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Types, codes and serial-number helpers for the reassembly range tracker.
// ----------------------------------------------------------------------------
package trt_pkg;

    localparam int RANGE_SLOTS_DEF = 32;
    localparam logic [20:0] BUF_RESET = 21'd65536;
    localparam logic [15:0] WINDOW_MAX = 16'd65535;

    localparam logic [1:0] FUNC_SEGMENT = 2'd0;
    localparam logic [1:0] FUNC_CONSUME = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;

    localparam logic [1:0] STATUS_DUP     = 2'd0;
    localparam logic [1:0] STATUS_BEYOND  = 2'd1;
    localparam logic [1:0] STATUS_HELD    = 2'd2;
    localparam logic [1:0] STATUS_ADVANCE = 2'd3;

    typedef enum logic [1:0] {
        OP_SEG,
        OP_CONSUME,
        OP_START,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] seq_number;
        logic [15:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_expected;
        logic [20:0] delivered_bytes;
        logic [5:0]  held_ranges;
        logic        table_full;
        logic        immediate_ack;
        logic [15:0] window;
    } out_item_t;

    // decoded command handed from front to back
    typedef struct packed {
        op_t         op;
        logic        empty;
        logic [31:0] seq;
        logic [31:0] seg_end;
        logic [15:0] cnt;
    } cmd_t;

    function automatic logic sq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic sq_le(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || sq_lt(a, b);
    endfunction

    function automatic logic sq_gt(input logic [31:0] a, input logic [31:0] b);
        return sq_lt(b, a);
    endfunction

endpackage

// ===== rtl/core/trt_front.sv =====
// ----------------------------------------------------------------------------
// trt_front
// Accepts input items and decodes them into commands for the queue.
// ----------------------------------------------------------------------------
module trt_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  trt_pkg::in_item_t s_data,
    output logic              push,
    output trt_pkg::cmd_t     push_cmd,
    input  logic              q_full
);

    always_comb begin
        s_ready          = !q_full;
        push             = s_valid && !q_full;
        push_cmd.seq     = s_data.seq_number;
        push_cmd.cnt     = s_data.byte_count;
        push_cmd.seg_end = s_data.seq_number + {16'd0, s_data.byte_count};
        push_cmd.empty   = (s_data.byte_count == 16'd0);
        unique case (s_data.func)
            trt_pkg::FUNC_SEGMENT: push_cmd.op = trt_pkg::OP_SEG;
            trt_pkg::FUNC_CONSUME: push_cmd.op = trt_pkg::OP_CONSUME;
            trt_pkg::FUNC_START:   push_cmd.op = trt_pkg::OP_START;
            default:               push_cmd.op = trt_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/trt_queue.sv =====
// ----------------------------------------------------------------------------
// trt_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module trt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  trt_pkg::cmd_t push_cmd,
    output logic          q_full,
    input  logic          pop,
    output logic          q_avail,
    output trt_pkg::cmd_t pop_cmd
);

    trt_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;

    assign q_full  = (fill_reg == 2'd2);
    assign q_avail = (fill_reg != 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/trt_back.sv =====
// ----------------------------------------------------------------------------
// trt_back
// Executes commands: range table merge, in-order advance, consume, start.
// ----------------------------------------------------------------------------
module trt_back #(
    parameter int RANGE_SLOTS = trt_pkg::RANGE_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [20:0]        cfg_wr_data,
    input  logic               q_avail,
    input  trt_pkg::cmd_t      pop_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output trt_pkg::out_item_t m_data
);

    localparam int IW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int CW = $clog2(RANGE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(RANGE_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_CMP,
        ST_RM_RD,
        ST_RM_WR,
        ST_INS,
        ST_ADV_END,
        ST_FIN
    } state_t;

    state_t        state_reg;
    trt_pkg::cmd_t cmd_reg;
    logic [20:0]   buf_reg;
    logic [31:0]   exp_reg;
    logic [31:0]   rp_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] k_reg;
    logic [31:0]   acc_s_reg;
    logic [31:0]   acc_e_reg;
    logic [31:0]   nxt_reg;
    logic          chg_reg;
    logic          adv_mode_reg;
    logic [1:0]    status_reg;
    logic [20:0]   deliv_reg;
    logic          full_reg;
    logic          ack_reg;
    logic          m_valid_reg;
    trt_pkg::out_item_t m_data_reg;

    // range table
    logic [31:0] mem_s [RANGE_SLOTS];
    logic [31:0] mem_e [RANGE_SLOTS];
    logic [31:0] rd_s_reg;
    logic [31:0] rd_e_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [31:0]   wr_s;
    logic [31:0]   wr_e;

    logic [31:0] limit;
    logic [31:0] clip_end;
    logic [31:0] buffered;
    logic [31:0] consume_n;
    logic        k_is_last;
    logic [33:0] win_full;
    logic [15:0] win;
    logic        touch;
    logic        fin_ok;
    logic        seg_live;
    logic        seg_dup;
    logic        seg_beyond;
    logic        seg_take;
    logic        at_cap;

    always_comb begin
        limit     = rp_reg + {11'd0, buf_reg};
        clip_end  = trt_pkg::sq_gt(cmd_reg.seg_end, limit) ? limit : cmd_reg.seg_end;
        buffered  = exp_reg - rp_reg;
        consume_n = ({16'd0, cmd_reg.cnt} < buffered) ? {16'd0, cmd_reg.cnt} : buffered;
        k_is_last = (CW'(k_reg + 1'b1) == cnt_reg);
        touch     = trt_pkg::sq_le(acc_s_reg, rd_e_reg) && trt_pkg::sq_le(rd_s_reg, acc_e_reg);
        win_full  = {13'd0, buf_reg} - {{2{buffered[31]}}, buffered};
        if (win_full[33]) begin
            win = 16'd0;
        end else if (win_full[32:16] != 17'd0) begin
            win = trt_pkg::WINDOW_MAX;
        end else begin
            win = win_full[15:0];
        end
        fin_ok = !m_valid_reg || m_ready;
        seg_live   = (cmd_reg.op == trt_pkg::OP_SEG) && !cmd_reg.empty;
        seg_dup    = seg_live && trt_pkg::sq_le(cmd_reg.seg_end, exp_reg);
        seg_beyond = seg_live && !seg_dup && !trt_pkg::sq_lt(cmd_reg.seq, limit);
        seg_take   = seg_live && !seg_dup && !seg_beyond;
        // no room: item's range is lost, advance still runs
        at_cap     = seg_take && (cnt_reg == SLOTS);
    end

    always_comb begin
        rd_addr = (state_reg == ST_RM_RD) ? cnt_reg[IW-1:0] : k_reg[IW-1:0];
        wr_en   = (state_reg == ST_RM_WR) || (state_reg == ST_INS);
        wr_addr = (state_reg == ST_INS) ? cnt_reg[IW-1:0] : k_reg[IW-1:0];
        wr_s    = (state_reg == ST_INS) ? acc_s_reg : rd_s_reg;
        wr_e    = (state_reg == ST_INS) ? acc_e_reg : rd_e_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_s[wr_addr] <= wr_s;
            mem_e[wr_addr] <= wr_e;
        end
        rd_s_reg <= mem_s[rd_addr];
        rd_e_reg <= mem_e[rd_addr];
    end

    assign pop     = (state_reg == ST_IDLE) && q_avail;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            buf_reg     <= trt_pkg::BUF_RESET;
            exp_reg     <= 32'd0;
            rp_reg      <= 32'd0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) buf_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready && state_reg != ST_FIN) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_avail) begin
                        cmd_reg   <= pop_cmd;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    deliv_reg    <= 21'd0;
                    k_reg        <= '0;
                    chg_reg      <= 1'b0;
                    nxt_reg      <= exp_reg;
                    acc_s_reg    <= cmd_reg.seq;
                    acc_e_reg    <= clip_end;
                    status_reg   <= seg_beyond ? trt_pkg::STATUS_BEYOND : trt_pkg::STATUS_DUP;
                    ack_reg      <= seg_dup || seg_beyond;
                    full_reg     <= at_cap;
                    adv_mode_reg <= at_cap;
                    state_reg    <= seg_take ? ST_SCAN : ST_FIN;
                    unique case (cmd_reg.op)
                        trt_pkg::OP_CONSUME: begin
                            if (!buffered[31] && buffered != 32'd0) begin
                                rp_reg <= rp_reg + consume_n;
                            end
                        end
                        trt_pkg::OP_START: begin
                            exp_reg <= cmd_reg.seq + 32'd1;
                            rp_reg  <= cmd_reg.seq + 32'd1;
                            cnt_reg <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (k_reg == cnt_reg) begin
                        k_reg   <= '0;
                        chg_reg <= 1'b0;
                        if (!chg_reg) begin
                            state_reg <= adv_mode_reg ? ST_ADV_END : ST_INS;
                        end
                    end else begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    priority if (!adv_mode_reg && touch) begin
                        if (trt_pkg::sq_lt(rd_s_reg, acc_s_reg)) acc_s_reg <= rd_s_reg;
                        if (trt_pkg::sq_gt(rd_e_reg, acc_e_reg)) acc_e_reg <= rd_e_reg;
                        chg_reg   <= 1'b1;
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= k_is_last ? ST_SCAN : ST_RM_RD;
                    end else if (adv_mode_reg && trt_pkg::sq_le(rd_s_reg, nxt_reg)) begin
                        if (trt_pkg::sq_gt(rd_e_reg, nxt_reg)) nxt_reg <= rd_e_reg;
                        chg_reg   <= 1'b1;
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= k_is_last ? ST_SCAN : ST_RM_RD;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_RM_RD: begin
                    state_reg <= ST_RM_WR;
                end
                ST_RM_WR: begin
                    // last entry moved into the hole; recheck same slot
                    state_reg <= ST_SCAN;
                end
                ST_INS: begin
                    cnt_reg      <= cnt_reg + 1'b1;
                    adv_mode_reg <= 1'b1;
                    state_reg    <= ST_SCAN;
                end
                ST_ADV_END: begin
                    if (trt_pkg::sq_gt(nxt_reg, exp_reg)) begin
                        deliv_reg  <= 21'(nxt_reg - exp_reg);
                        exp_reg    <= nxt_reg;
                        status_reg <= trt_pkg::STATUS_ADVANCE;
                        ack_reg    <= (cnt_reg != '0);
                    end else begin
                        status_reg <= trt_pkg::STATUS_HELD;
                        ack_reg    <= 1'b1;
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_ok) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.status          <= status_reg;
                        m_data_reg.next_expected   <= exp_reg;
                        m_data_reg.delivered_bytes <= deliv_reg;
                        m_data_reg.held_ranges     <= 6'(cnt_reg);
                        m_data_reg.table_full      <= full_reg;
                        m_data_reg.immediate_ack   <= ack_reg;
                        m_data_reg.window          <= win;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/tcp_reassembly_range_tracker.sv =====
// ----------------------------------------------------------------------------
// tcp_reassembly_range_tracker
// TCP receive reassembly tracker with an out-of-order range table.
// ----------------------------------------------------------------------------
// One item at a time is executed. Consume, start and rejected segments pass
// from the queue through the check state straight to the result. An accepted
// segment walks the range table through one memory read port: each pass
// visits every stored range in the scan and compare states, a removal adds
// the move read and write states, and merge and advance repeat passes until
// nothing changes. A two-entry queue lets the input take items while the
// engine works.
module tcp_reassembly_range_tracker #(
    parameter int RANGE_SLOTS = trt_pkg::RANGE_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [20:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  trt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output trt_pkg::out_item_t m_data
);

    logic          push;
    trt_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          pop;
    logic          q_avail;
    trt_pkg::cmd_t pop_cmd;

    trt_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    trt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .pop      (pop),
        .q_avail  (q_avail),
        .pop_cmd  (pop_cmd)
    );

    trt_back #(
        .RANGE_SLOTS (RANGE_SLOTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_avail     (q_avail),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== rtl/core/trt_checker.sv =====
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks on results of the reassembly tracker.
// ----------------------------------------------------------------------------
module trt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input trt_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_adv_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == trt_pkg::STATUS_ADVANCE |-> m_data.delivered_bytes != 21'd0)
        else $error("advance with nothing delivered");

    a_beyond_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == trt_pkg::STATUS_BEYOND |-> m_data.immediate_ack)
        else $error("beyond window without ack");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |->
            (m_data.status == trt_pkg::STATUS_HELD || m_data.status == trt_pkg::STATUS_ADVANCE))
        else $error("table full on non-accepted item");

endmodule

bind tcp_reassembly_range_tracker trt_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tcp_reassembly_range_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_reassembly_range_tracker_tb
// Self-checking bench: a queue-fed driver offers items with random gaps, a
// monitor compares every result against a cycle-free reassembly predictor,
// and the buffer size is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tcp_reassembly_range_tracker_tb;

    localparam int SLOTS      = trt_pkg::RANGE_SLOTS_DEF;
    localparam int STALL_LEN  = 400;
    localparam int WDOG_LIMIT = 40000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [20:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    trt_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    trt_pkg::out_item_t m_data;

    tcp_reassembly_range_tracker uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    logic [31:0] seg_lo [SLOTS];
    logic [31:0] seg_hi [SLOTS];
    int          seg_n;
    logic [31:0] rcv_next;
    logic [31:0] app_ptr;
    logic [20:0] buf_bytes;

    trt_pkg::in_item_t  pending_items[$];
    trt_pkg::out_item_t expected_results[$];
    int        mismatches;
    int        items_sent;
    int        results_seen;
    int        advances;
    int        full_drops;
    bit        idling_on;
    int        stall_reqs;

    function automatic bit ser_lt(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic bit ser_le(logic [31:0] a, logic [31:0] b);
        return (a == b) || ser_lt(a, b);
    endfunction

    function automatic void drop_range(int k);
        seg_n--;
        seg_lo[k] = seg_lo[seg_n];
        seg_hi[k] = seg_hi[seg_n];
    endfunction

    function automatic bit store_range(logic [31:0] lo, logic [31:0] hi);
        bit merged;
        int i;
        int j;
        if (seg_n >= SLOTS) return 1'b0;
        seg_lo[seg_n] = lo;
        seg_hi[seg_n] = hi;
        seg_n++;
        merged = 1'b1;
        while (merged) begin
            merged = 1'b0;
            for (i = 0; i < seg_n && !merged; i++) begin
                for (j = i + 1; j < seg_n; j++) begin
                    if (ser_le(seg_lo[i], seg_hi[j]) && ser_le(seg_lo[j], seg_hi[i])) begin
                        if (ser_lt(seg_lo[j], seg_lo[i])) seg_lo[i] = seg_lo[j];
                        if (ser_lt(seg_hi[i], seg_hi[j])) seg_hi[i] = seg_hi[j];
                        drop_range(j);
                        merged = 1'b1;
                        break;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] sweep_ranges(logic [31:0] nxt);
        bit changed;
        int i;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (i = 0; i < seg_n; i++) begin
                if (ser_le(seg_hi[i], nxt)) begin
                    drop_range(i);
                    changed = 1'b1;
                    break;
                end else if (ser_le(seg_lo[i], nxt)) begin
                    if (ser_lt(nxt, seg_hi[i])) nxt = seg_hi[i];
                    drop_range(i);
                    changed = 1'b1;
                    break;
                end
            end
        end
        return nxt;
    endfunction

    function automatic trt_pkg::out_item_t reassemble(trt_pkg::in_item_t it);
        trt_pkg::out_item_t r;
        logic [31:0] lim;
        logic [31:0] seg_end;
        logic [31:0] prev;
        logic [31:0] nxt;
        longint      buffered;
        longint      n;
        longint      w;
        r = '0;
        case (it.func)
            trt_pkg::FUNC_SEGMENT: begin
                if (it.byte_count != 0) begin
                    lim = app_ptr + 32'(buf_bytes);
                    seg_end = it.seq_number + 32'(it.byte_count);
                    if (ser_le(seg_end, rcv_next)) begin
                        r.immediate_ack = 1'b1;
                    end else if (!ser_lt(it.seq_number, lim)) begin
                        r.status = trt_pkg::STATUS_BEYOND;
                        r.immediate_ack = 1'b1;
                    end else begin
                        prev = rcv_next;
                        if (ser_lt(lim, seg_end)) seg_end = lim;
                        if (!store_range(it.seq_number, seg_end)) begin
                            r.table_full = 1'b1;
                            full_drops++;
                        end
                        nxt = sweep_ranges(prev);
                        if (ser_lt(prev, nxt)) begin
                            r.delivered_bytes = 21'(nxt - prev);
                            rcv_next = nxt;
                            r.status = trt_pkg::STATUS_ADVANCE;
                            advances++;
                        end else begin
                            r.status = trt_pkg::STATUS_HELD;
                            r.immediate_ack = 1'b1;
                        end
                        if (seg_n > 0) r.immediate_ack = 1'b1;
                    end
                end
            end
            trt_pkg::FUNC_CONSUME: begin
                buffered = longint'($signed(rcv_next - app_ptr));
                n = (longint'(it.byte_count) < buffered) ? longint'(it.byte_count) : buffered;
                if (n > 0) app_ptr = app_ptr + 32'(n);
            end
            trt_pkg::FUNC_START: begin
                rcv_next = it.seq_number + 32'd1;
                app_ptr = rcv_next;
                seg_n = 0;
            end
            default: ;
        endcase
        w = longint'(buf_bytes) - longint'($signed(rcv_next - app_ptr));
        if (w < 0) w = 0;
        if (w > 65535) w = 65535;
        r.next_expected = rcv_next;
        r.held_ranges = 6'(seg_n);
        r.window = 16'(w);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // driver
    int src_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(reassemble(s_data));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    if (idling_on && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 12);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    int sink_gap;
    int stalls_done;
    always @(posedge aclk) begin
        trt_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
            stalls_done = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("MISMATCH unexpected result %0d", results_seen);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.next_expected !== want.next_expected)
                        report_mismatch("next_expected", m_data.next_expected,
                                        want.next_expected);
                    if (m_data.delivered_bytes !== want.delivered_bytes)
                        report_mismatch("delivered_bytes", m_data.delivered_bytes,
                                        want.delivered_bytes);
                    if (m_data.held_ranges !== want.held_ranges)
                        report_mismatch("held_ranges", m_data.held_ranges, want.held_ranges);
                    if (m_data.table_full !== want.table_full)
                        report_mismatch("table_full", m_data.table_full, want.table_full);
                    if (m_data.immediate_ack !== want.immediate_ack)
                        report_mismatch("immediate_ack", m_data.immediate_ack,
                                        want.immediate_ack);
                    if (m_data.window !== want.window)
                        report_mismatch("window", m_data.window, want.window);
                end
                results_seen++;
            end
            if (stall_reqs != stalls_done) begin
                stalls_done++;
                sink_gap = STALL_LEN;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 12);
            end
        end
    end

    // watchdog on cycles without any item moving
    int quiet;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("timeout: no progress for %0d cycles", quiet);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic trt_pkg::in_item_t mk(logic [1:0] f, logic [31:0] s, logic [15:0] c);
        trt_pkg::in_item_t it;
        it.func = f;
        it.seq_number = s;
        it.byte_count = c;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_buffer(logic [20:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        buf_bytes = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed traffic around a tracked stream position
    task automatic queue_stream(int count);
        logic [31:0] pos;
        logic [31:0] s;
        int          i;
        int          k;
        int          sel;
        int          len;
        pos = $urandom;
        pending_items.push_back(mk(trt_pkg::FUNC_START, pos - 1, 16'($urandom)));
        for (i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            len = $urandom_range(1, 1500);
            if (sel < 35) begin
                pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, pos, 16'(len)));
                pos += len;
            end else if (sel < 60) begin
                s = pos + $urandom_range(1, 30000);
                pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, s, 16'(len)));
            end else if (sel < 68) begin
                s = pos - $urandom_range(0, 3000);
                pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, s,
                                           16'($urandom_range(0, 3000))));
            end else if (sel < 85) begin
                pending_items.push_back(mk(trt_pkg::FUNC_CONSUME, $urandom,
                                           16'($urandom_range(0, 20000))));
            end else if (sel < 88) begin
                // scatter many small islands to fill the table
                for (k = 0; k < 36; k++)
                    pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, pos + 200 + k * 40,
                                               16'(10)));
                i += 36;
            end else if (sel < 90) begin
                pos = $urandom;
                pending_items.push_back(mk(trt_pkg::FUNC_START, pos - 1, 16'($urandom)));
            end else begin
                pending_items.push_back(mk(2'($urandom_range(0, 3)), $urandom, 16'($urandom)));
            end
        end
    endtask

    initial begin
        logic [20:0] buf_vals [5];
        int p;
        seg_n = 0;
        rcv_next = '0;
        app_ptr = '0;
        buf_bytes = trt_pkg::BUF_RESET;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        advances = 0;
        full_drops = 0;
        stall_reqs = 0;
        idling_on = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default buffer, wrap, extremes and every function
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'd0, 16'd0));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'd0, 16'd100));
        pending_items.push_back(mk(trt_pkg::FUNC_START, 32'hFFFF_FFFF, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_START, 32'hFFFF_FFEF, 16'd0));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'hFFFF_FFF0, 16'd0));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'h0000_0100, 16'd50));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'hFFFF_FFF0, 16'd300));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'hFFFF_FF00, 16'd200));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'h0001_0000, 16'd10));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'h0000_0400, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'h0000_0200, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_CONSUME, 32'd0, 16'd0));
        pending_items.push_back(mk(trt_pkg::FUNC_CONSUME, 32'hFFFF_FFFF, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_CONSUME, 32'd0, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::OP_NOP, 32'hFFFF_FFFF, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_START, 32'd0, 16'd0));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'h8000_0000, 16'hFFFF));
        pending_items.push_back(mk(trt_pkg::FUNC_SEGMENT, 32'd1, 16'hFFFF));
        drain();

        // receiver holds off while the sender keeps offering
        stall_reqs <= stall_reqs + 1;
        queue_stream(60);
        drain();

        buf_vals[0] = 21'd1;
        buf_vals[1] = 21'd1048576;
        buf_vals[2] = 21'd300;
        buf_vals[3] = 21'($urandom_range(1, 1048576));
        buf_vals[4] = trt_pkg::BUF_RESET;
        for (p = 0; p < 5; p++) begin
            set_buffer(buf_vals[p]);
            if (p == 4) idling_on = 1'b0;
            queue_stream(p == 0 ? 60 : 330);
            // sender waits for every result before moving on
            drain();
        end

        $display("Ran %0d items, checked %0d results over 6 buffer settings;",
                 items_sent, results_seen);
        $display("%0d segments advanced the stream, %0d ranges lost to a full table.",
                 advances, full_drops);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/trt_pkg.sv
rtl/core/trt_front.sv
rtl/core/trt_queue.sv
rtl/core/trt_back.sv
rtl/core/tcp_reassembly_range_tracker.sv
rtl/core/trt_checker.sv
verif/tcp_reassembly_range_tracker_tb.sv
